>>> design/quadrature_detent_click_decoder_top_assert.svh
// ----------------------------------------------------------------------------
// quadrature detent click decoder assertion macros
// shared assertion forms for the checker, sampled on the rising clock edge
// ----------------------------------------------------------------------------
`ifndef QUADRATURE_DETENT_CLICK_DECODER_TOP_ASSERT_SVH
`define QUADRATURE_DETENT_CLICK_DECODER_TOP_ASSERT_SVH

// checked only outside reset
`define QDCD_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// checked on every edge, reset included
`define QDCD_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

>>> design/qdcd_pkg.sv
// ----------------------------------------------------------------------------
// qdcd_pkg
// types, constants and the transition decode shared by the decoder modules
// ----------------------------------------------------------------------------
package qdcd_pkg;

   localparam int POSITION_WIDTH     = 32;
   localparam int RSP_POSITION_WIDTH = 32;
   localparam int POS_EXT_WIDTH      = 64;
   localparam int TIMEOUT_WIDTH      = 16;
   localparam int RUN_WIDTH          = 4;

   localparam logic [TIMEOUT_WIDTH-1:0] TIMEOUT_RESET = TIMEOUT_WIDTH'(40);
   localparam logic [TIMEOUT_WIDTH-1:0] ELAPSED_MAX   = '1;
   localparam logic signed [RUN_WIDTH-1:0] RUN_MAX    = 4'sd4;
   localparam logic signed [RUN_WIDTH-1:0] RUN_MIN    = -4'sd4;

   typedef enum logic [1:0] {
      CLICK_NONE  = 2'd0,
      CLICK_RIGHT = 2'd1,
      CLICK_LEFT  = 2'd2
   } click_type;

   typedef enum logic [1:0] {
      STEP_NONE,
      STEP_UP,
      STEP_DOWN
   } step_type;

   typedef struct packed {
      logic phase_msb;
      logic phase_lsb;
      logic ms_tick;
   } item_type;

   typedef struct packed {
      click_type                      click;
      logic [RSP_POSITION_WIDTH-1:0] position;
   } result_type;

   // old pair in the upper two bits, new pair in the lower two
   function automatic step_type step_decode(input logic [3:0] code);
      step_type dir;
      case (code) inside
         4'b1101, 4'b0100, 4'b0010, 4'b1011: dir = STEP_UP;
         4'b1110, 4'b0111, 4'b0001, 4'b1000: dir = STEP_DOWN;
         default:                           dir = STEP_NONE;
      endcase
      return dir;
   endfunction

endpackage

>>> design/qdcd_in_stage.sv
// ----------------------------------------------------------------------------
// qdcd_in_stage
// input register holding one sampled item until the update logic takes it
// ----------------------------------------------------------------------------
module qdcd_in_stage import qdcd_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  item_type req_item,
   input  logic     take,
   output logic     item_valid,
   output item_type item
);

   logic     valid_ff, valid_in;
   item_type item_ff,  item_in;

   assign req_ready = !valid_ff || take;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
         item_in  = req_item;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

>>> design/qdcd_core.sv
// ----------------------------------------------------------------------------
// qdcd_core
// decoder state and the single-pass update of position, step run and timer
// ----------------------------------------------------------------------------
module qdcd_core import qdcd_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  logic [TIMEOUT_WIDTH-1:0] csr_wr_data,
   input  logic                     fire,
   input  item_type                 item,
   output result_type               result
);

   logic [1:0]                 last_ff,    last_in;
   logic [POSITION_WIDTH-1:0]  pos_ff,     pos_in;
   logic signed [RUN_WIDTH-1:0] run_ff,    run_in;
   logic                       armed_ff,   armed_in;
   logic [TIMEOUT_WIDTH-1:0]   elapsed_ff, elapsed_in;
   logic [TIMEOUT_WIDTH-1:0]   timeout_ff;

   logic [1:0]                 phases;
   step_type                   dir;
   logic signed [RUN_WIDTH-1:0] run_step;
   logic [TIMEOUT_WIDTH-1:0]   elapsed_step;
   logic                       expired;
   logic                       armed_mid;
   logic [POS_EXT_WIDTH-1:0]   pos_ext;
   click_type                  click;

   assign phases = {item.phase_msb, item.phase_lsb};
   assign dir    = step_decode({last_ff, phases});

   always_comb begin
      pos_in   = pos_ff;
      run_step = run_ff;
      case (dir)
         STEP_UP: begin
            pos_in = pos_ff + POSITION_WIDTH'(1);
            if (run_ff < RUN_MAX) run_step = run_ff + 4'sd1;
         end
         STEP_DOWN: begin
            pos_in = pos_ff - POSITION_WIDTH'(1);
            if (run_ff > RUN_MIN) run_step = run_ff - 4'sd1;
         end
         default: begin
            pos_in   = pos_ff;
            run_step = run_ff;
         end
      endcase

      elapsed_step = elapsed_ff;
      if (armed_ff && item.ms_tick && elapsed_ff != ELAPSED_MAX)
         elapsed_step = elapsed_ff + TIMEOUT_WIDTH'(1);

      expired    = armed_ff && (elapsed_step >= timeout_ff);
      run_in     = expired ? '0 : run_step;
      armed_mid  = armed_ff && !expired;
      elapsed_in = expired ? '0 : elapsed_step;

      click = CLICK_NONE;
      if (run_in == RUN_MAX) click = CLICK_RIGHT;
      else if (run_in == RUN_MIN) click = CLICK_LEFT;

      armed_in = armed_mid;
      if (click != CLICK_NONE && !armed_mid) begin
         armed_in   = 1'b1;
         elapsed_in = '0;
      end

      last_in = phases;
   end

   // sign-extend or cut the position count to the result width
   assign pos_ext         = POS_EXT_WIDTH'(signed'(pos_in));
   assign result.click    = click;
   assign result.position = pos_ext[RSP_POSITION_WIDTH-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff    <= '0;
         pos_ff     <= '0;
         run_ff     <= '0;
         armed_ff   <= 1'b0;
         elapsed_ff <= '0;
         timeout_ff <= TIMEOUT_RESET;
      end else begin
         if (fire) begin
            last_ff    <= last_in;
            pos_ff     <= pos_in;
            run_ff     <= run_in;
            armed_ff   <= armed_in;
            elapsed_ff <= elapsed_in;
         end
         if (csr_wr_en) timeout_ff <= csr_wr_data;
      end
   end

endmodule

>>> design/qdcd_out_stage.sv
// ----------------------------------------------------------------------------
// qdcd_out_stage
// result register holding one item until the consumer takes it
// ----------------------------------------------------------------------------
module qdcd_out_stage import qdcd_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  result_type                    result,
   output logic                          space,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [1:0]                    rsp_click,
   output logic [RSP_POSITION_WIDTH-1:0] rsp_position
);

   logic       valid_ff, valid_in;
   result_type result_ff;

   assign space = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) valid_in = 1'b1;
      else if (rsp_ready) valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) result_ff <= result;
   end

   assign rsp_valid    = valid_ff;
   assign rsp_click    = result_ff.click;
   assign rsp_position = result_ff.position;

endmodule

>>> design/quadrature_detent_click_decoder_top.sv
// ----------------------------------------------------------------------------
// quadrature_detent_click_decoder_top
// x4 quadrature decoder with detent click detection and click timeout
// ----------------------------------------------------------------------------
// takes one item per clock cycle when the consumer keeps up; a result passes
// through the input register and then the result register, with the whole
// state update done in the single combinational pass between them; each item
// gives exactly one result: the click code (0 none, 1 right, 2 left) and the
// signed position after the item; csr_wr_data sets the click timeout in ms and
// must be written only while idle, which the block itself does not enforce
module quadrature_detent_click_decoder_top import qdcd_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   // input item channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_phase_msb,
   input  logic                          req_phase_lsb,
   input  logic                          req_ms_tick,
   // result item channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [1:0]                    rsp_click,
   output logic signed [RSP_POSITION_WIDTH-1:0] rsp_position,
   // timeout register write
   input  logic                          csr_wr_en,
   input  logic [TIMEOUT_WIDTH-1:0]      csr_wr_data
);

   item_type   req_item, item;
   logic       item_valid;
   logic       space;
   logic       advance;
   result_type result;
   logic [RSP_POSITION_WIDTH-1:0] position;

   assign req_item = '{phase_msb: req_phase_msb, phase_lsb: req_phase_lsb,
                       ms_tick: req_ms_tick};

   // an item moves to the result register when that register is free or drains
   assign advance = item_valid && space;

   qdcd_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .take       (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   // state is committed in the same cycle the result is loaded
   qdcd_core u_core (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fire        (advance),
      .item        (item),
      .result      (result)
   );

   qdcd_out_stage u_out (
      .clock        (clock),
      .reset        (reset),
      .load         (advance),
      .result       (result),
      .space        (space),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_click    (rsp_click),
      .rsp_position (position)
   );

   assign rsp_position = signed'(position);

endmodule

>>> design/qdcd_checker.sv
// ----------------------------------------------------------------------------
// qdcd_checker
// port-level checks on item flow and result stability, bound to the top level
// ----------------------------------------------------------------------------
`include "quadrature_detent_click_decoder_top_assert.svh"

module qdcd_checker import qdcd_pkg::*; (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [1:0]                    rsp_click,
   input logic [RSP_POSITION_WIDTH-1:0] rsp_position
);

   // items accepted but not yet delivered
   logic [1:0] pending_ff, pending_in;
   logic       req_take, rsp_take;

   assign req_take = req_valid && req_ready;
   assign rsp_take = rsp_valid && rsp_ready;

   always_comb begin
      pending_in = pending_ff;
      if (req_take && !rsp_take) pending_in = pending_ff + 2'd1;
      else if (rsp_take && !req_take) pending_in = pending_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   `QDCD_ASSERT_ALWAYS(a_reset_empty, $past(reset) |-> (!rsp_valid && req_ready), "result or stall right after reset")
   `QDCD_ASSERT(a_no_phantom, rsp_valid |-> (pending_ff != 2'd0), "result item with no accepted item")
   `QDCD_ASSERT(a_depth, pending_ff != 2'd3, "more items in flight than the pipeline holds")
   `QDCD_ASSERT(a_rsp_hold, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_click) && $stable(rsp_position)), "stalled result changed")

endmodule

bind quadrature_detent_click_decoder_top qdcd_checker u_qdcd_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_click    (rsp_click),
   .rsp_position (rsp_position)
);

>>> bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quadrature detent click decoder testbench
// drives phase samples through the valid/ready input channel, predicts the
// click code and position of every sample and checks each result item in
// order, across several click timeout settings with random idling both sides
// ----------------------------------------------------------------------------
module testbench;
   import qdcd_pkg::*;

   logic                                  clock         = 1'b0;
   logic                                  reset         = 1'b1;
   logic                                  req_valid     = 1'b0;
   logic                                  req_ready;
   logic                                  req_phase_msb = 1'b0;
   logic                                  req_phase_lsb = 1'b0;
   logic                                  req_ms_tick   = 1'b0;
   logic                                  rsp_valid;
   logic                                  rsp_ready     = 1'b0;
   logic [1:0]                            rsp_click;
   logic signed [RSP_POSITION_WIDTH-1:0]  rsp_position;
   logic                                  csr_wr_en     = 1'b0;
   logic [TIMEOUT_WIDTH-1:0]              csr_wr_data   = '0;

   quadrature_detent_click_decoder_top dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_phase_msb (req_phase_msb),
      .req_phase_lsb (req_phase_lsb),
      .req_ms_tick   (req_ms_tick),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_click     (rsp_click),
      .rsp_position  (rsp_position),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // decoder state as the bench sees it
   // ------------------------------------------------------------------------
   logic [1:0]                 prev_pair         = 2'b00;
   logic [POSITION_WIDTH-1:0]  step_position     = '0;
   int                         detent_run        = 0;   // -4 .. +4
   logic                       click_timer_armed = 1'b0;
   logic [TIMEOUT_WIDTH-1:0]   click_elapsed     = '0;
   logic [TIMEOUT_WIDTH-1:0]   click_timeout     = TIMEOUT_RESET;

   item_type   sample_queue[$];        // samples waiting for the driver
   result_type predicted_reports[$];   // click/position per accepted item

   int  sent_count   = 0;
   int  taken_count  = 0;
   int  error_count  = 0;
   int  right_count  = 0;
   int  left_count   = 0;
   int  clear_count  = 0;
   int  send_gap     = 0;
   int  recv_stall   = 0;
   logic idle_en     = 1'b1;   // random idling on both channels

   // gray ring for the stimulus walk: moving forward is one up step
   logic [1:0] walk_ring [4] = '{2'b00, 2'b10, 2'b11, 2'b01};
   int         walk_pos      = 0;
   logic       walk_up       = 1'b1;

   // old pair in the upper bits, new pair in the lower bits
   function automatic step_type transition_dir(input logic [3:0] code);
      step_type dir;
      case (code)
         4'b1101, 4'b0100, 4'b0010, 4'b1011: dir = STEP_UP;
         4'b1110, 4'b0111, 4'b0001, 4'b1000: dir = STEP_DOWN;
         default:                           dir = STEP_NONE;
      endcase
      return dir;
   endfunction

   // advance the predicted decoder by one sample and queue its result
   task automatic decode_sample(input item_type s);
      logic [1:0] pair;
      step_type   dir;
      result_type r;
      pair      = {s.phase_msb, s.phase_lsb};
      dir       = transition_dir({prev_pair, pair});
      prev_pair = pair;
      // position and step run first
      if (dir == STEP_UP) begin
         step_position = step_position + 1'b1;
         if (detent_run < 4) detent_run++;
      end else if (dir == STEP_DOWN) begin
         step_position = step_position - 1'b1;
         if (detent_run > -4) detent_run--;
      end
      // then the timeout, counting ticks only while armed
      if (click_timer_armed && s.ms_tick && click_elapsed != ELAPSED_MAX)
         click_elapsed = click_elapsed + 1'b1;
      if (click_timer_armed && click_elapsed >= click_timeout) begin
         detent_run        = 0;
         click_timer_armed = 1'b0;
         click_elapsed     = '0;
         clear_count++;
      end
      // a saturated run reports a click and starts the timer once
      r.click = CLICK_NONE;
      if (detent_run == 4 || detent_run == -4) begin
         r.click = (detent_run == 4) ? CLICK_RIGHT : CLICK_LEFT;
         if (detent_run == 4) right_count++;
         else left_count++;
         if (!click_timer_armed) begin
            click_timer_armed = 1'b1;
            click_elapsed     = '0;
         end
      end
      r.position = step_position;
      predicted_reports.push_back(r);
   endtask

   task automatic report_error(input string msg);
      $display("%0t ns mismatch: %s", $time, msg);
      error_count++;
   endtask

   task automatic queue_sample(input logic a, input logic b, input logic tick);
      item_type s;
      s.phase_msb = a;
      s.phase_lsb = b;
      s.ms_tick   = tick;
      sample_queue.push_back(s);
   endtask

   // mostly a steady rotation with random ticks; some reversals, holds,
   // double changes and arbitrary jumps mixed in
   task automatic queue_walk(input int count, input int tick_pct);
      int roll;
      for (int i = 0; i < count; i++) begin
         roll = $urandom_range(0, 99);
         if ($urandom_range(0, 15) == 0) walk_up = ~walk_up;
         if (roll < 55)
            walk_pos = walk_up ? walk_pos + 1 : walk_pos + 3;
         else if (roll < 65)
            walk_pos = walk_up ? walk_pos + 3 : walk_pos + 1;
         else if (roll >= 88)
            walk_pos = $urandom_range(0, 3);
         else if (roll >= 80)
            walk_pos = walk_pos + 2;
         walk_pos = walk_pos % 4;
         queue_sample(walk_ring[walk_pos][1], walk_ring[walk_pos][0],
                      $urandom_range(0, 99) < tick_pct);
      end
   endtask

   // wait until every queued sample has come back, then let the pipe settle
   task automatic drain_results;
      do @(negedge clock);
      while (sample_queue.size() != 0 || sent_count != taken_count ||
             predicted_reports.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_timeout(input logic [TIMEOUT_WIDTH-1:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      click_timeout = value;
   endtask

   // ------------------------------------------------------------------------
   // driver: one item per handshake, random idle bursts between items
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : driver
      item_type taken;
      item_type next_item;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  = 0;
      end else begin
         if (req_valid && req_ready) begin
            taken.phase_msb = req_phase_msb;
            taken.phase_lsb = req_phase_lsb;
            taken.ms_tick   = req_ms_tick;
            decode_sample(taken);
            taken_count++;
         end
         // an item not yet accepted stays on the port unchanged
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (sample_queue.size() != 0 && idle_en &&
                         $urandom_range(0, 5) == 0) begin
               send_gap = $urandom_range(0, 17);
               req_valid <= 1'b0;
            end else if (sample_queue.size() != 0) begin
               next_item = sample_queue.pop_front();
               req_valid     <= 1'b1;
               req_phase_msb <= next_item.phase_msb;
               req_phase_lsb <= next_item.phase_lsb;
               req_ms_tick   <= next_item.ms_tick;
               sent_count++;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // monitor: checks each result item against the oldest prediction
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      result_type want;
      if (reset) begin
         rsp_ready  <= 1'b0;
         recv_stall = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (predicted_reports.size() == 0) begin
               report_error($sformatf("unexpected result, click %0d position %0d",
                                      rsp_click, rsp_position));
            end else begin
               want = predicted_reports.pop_front();
               if (rsp_click !== want.click)
                  report_error($sformatf("click %0d, expected %0d",
                                         rsp_click, want.click));
               if (rsp_position !== want.position)
                  report_error($sformatf("position %0d, expected %0d",
                                         rsp_position, $signed(want.position)));
            end
         end
         if (recv_stall > 0) begin
            recv_stall--;
            rsp_ready <= 1'b0;
         end else if (idle_en && $urandom_range(0, 5) == 0) begin
            recv_stall = $urandom_range(0, 17);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // stimulus sequence
   // ------------------------------------------------------------------------
   initial begin : stimulus
      logic [TIMEOUT_WIDTH-1:0] phase_timeout [8];
      phase_timeout = '{16'd1, 16'hFFFF, 16'd2, 16'd0, 16'd5, 16'd9, 16'd3, 16'd1};
      phase_timeout[5] = TIMEOUT_WIDTH'($urandom_range(0, 12));

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset timeout of 40 ms: no change, a full up rotation to a right
      // click, then double changes while the click keeps repeating
      queue_sample(1'b0, 1'b0, 1'b0);
      queue_sample(1'b1, 1'b0, 1'b1);
      queue_sample(1'b1, 1'b1, 1'b0);
      queue_sample(1'b0, 1'b1, 1'b0);
      queue_sample(1'b0, 1'b0, 1'b1);
      queue_sample(1'b0, 1'b0, 1'b1);
      queue_sample(1'b1, 1'b1, 1'b0);
      queue_sample(1'b0, 1'b0, 1'b1);
      queue_sample(1'b0, 1'b0, 1'b0);
      // the sender holds off here until every result is back
      drain_results();

      // zero timeout: the armed timer clears the run on the next sample,
      // then a down rotation to a left click, cleared again right after
      write_timeout(16'd0);
      queue_sample(1'b0, 1'b1, 1'b0);
      queue_sample(1'b1, 1'b1, 1'b1);
      queue_sample(1'b1, 1'b0, 1'b0);
      queue_sample(1'b0, 1'b0, 1'b1);
      queue_sample(1'b0, 1'b1, 1'b0);
      queue_sample(1'b0, 1'b1, 1'b0);
      queue_sample(1'b1, 1'b0, 1'b1);
      queue_sample(1'b0, 1'b1, 1'b1);
      queue_sample(1'b1, 1'b1, 1'b1);
      queue_sample(1'b1, 1'b1, 1'b0);
      drain_results();

      // random walks, one timeout setting per phase; one stretch and the
      // final phase run with both channels never idling
      for (int p = 0; p < 8; p++) begin
         idle_en = (p != 3 && p != 7);
         write_timeout(phase_timeout[p]);
         queue_walk(245, $urandom_range(10, 95));
         drain_results();
      end

      $display("covered %0d samples over 10 click timeout settings, 0 and 65535 included",
               taken_count);
      $display("saw %0d right and %0d left click results and %0d timeout clears",
               right_count, left_count, clear_count);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // watchdog, far beyond the slowest correct run
   initial begin : watchdog
      #5_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
